// ===== src/assert_macros.svh =====
// Assertion macros shared by the deframer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside reset
`define DFR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset
`define DFR_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// ===== src/dfr_pkg.sv =====
// Shared types, codes and CRC function for the packet deframer
package dfr_pkg;

  localparam logic [7:0]  SYNC_FIRST    = 8'h5A;
  localparam logic [7:0]  SYNC_SECOND   = 8'hA5;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_TOP       = 16'h8000;
  localparam logic [15:0] MAX_LEN_RESET = 16'd1017;

  // result kinds
  localparam logic [2:0] KIND_PAYLOAD = 3'd0;
  localparam logic [2:0] KIND_GOOD    = 3'd1;
  localparam logic [2:0] KIND_CRC_ERR = 3'd2;
  localparam logic [2:0] KIND_LEN_ERR = 3'd3;
  localparam logic [2:0] KIND_TIMEOUT = 3'd4;

  // input function codes
  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_TIMEOUT = 1'b1;

  // result queue between parser and output stage
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [7:0] {
    PH_HUNT1   = 8'b0000_0001,
    PH_HUNT2   = 8'b0000_0010,
    PH_TYPE    = 8'b0000_0100,
    PH_LEN_L   = 8'b0000_1000,
    PH_LEN_H   = 8'b0001_0000,
    PH_PAYLOAD = 8'b0010_0000,
    PH_CRC_L   = 8'b0100_0000,
    PH_CRC_H   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  packet_type;
    logic [15:0] packet_len;
    logic [15:0] byte_index;
    logic        is_last;
  } result_t;

  // CRC-16, poly 0x1021, MSB first, one byte per call
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== src/crc16_packet_deframer_core.sv =====
// Top level of the CRC-16 packet deframer
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  item in  | item_valid / item_stall  | func, rx_byte
//  result   | res_valid / res_stall    | kind, payload_byte, packet_type,
//           |                          | packet_len, byte_index, is_last
//  config   | cfg_valid / cfg_ready    | cfg_data (max_payload_len)
//
// One item per cycle while item_stall is low; each item is parsed and its CRC updated
// in the cycle it is accepted (byte-wide unrolled CRC-16), and any result enters a
// 2-entry queue and then the output register, which drives res_valid.
// item_stall rises only when the result queue is full, i.e. after res_stall backs up.
// Reset (rst, synchronous) returns to sync hunt with max_payload_len = 1017.
// cfg_ready is always high; writes take effect on the next cycle.

module crc16_packet_deframer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [2:0]  kind,
  output logic [7:0]  payload_byte,
  output logic [7:0]  packet_type,
  output logic [15:0] packet_len,
  output logic [15:0] byte_index,
  output logic        is_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);
  import dfr_pkg::*;

  logic    push, pop, q_full, q_valid;
  result_t push_data, q_data, res;

  assign cfg_ready = 1'b1;

  dfr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .rx_byte    (rx_byte),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_data   (cfg_data),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data)
  );

  dfr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  dfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  assign kind         = res.kind;
  assign payload_byte = res.payload_byte;
  assign packet_type  = res.packet_type;
  assign packet_len   = res.packet_len;
  assign byte_index   = res.byte_index;
  assign is_last      = res.is_last;

endmodule

// ===== src/dfr_front.sv =====
// Frame parser: sync hunt, header, payload pass-through and CRC check
`include "assert_macros.svh"

module dfr_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              func,
  input  logic [7:0]        rx_byte,
  input  logic              cfg_wr,
  input  logic [15:0]       cfg_data,
  input  logic              q_full,
  output logic              push,
  output dfr_pkg::result_t  push_data
);
  import dfr_pkg::*;

  phase_t      phase, phase_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  frame_type, frame_type_next;
  logic [15:0] frame_length, frame_length_next;
  logic [15:0] payload_count, payload_count_next;
  logic [7:0]  crc_low_byte, crc_low_byte_next;
  logic [15:0] max_len;

  logic        accept;
  logic [15:0] crc_upd;
  logic [15:0] len_full;
  logic [15:0] count_inc;
  logic [15:0] crc_got;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign crc_upd    = crc16_byte((phase == PH_TYPE) ? 16'h0000 : running_crc, rx_byte);
  assign len_full   = {rx_byte, frame_length[7:0]};
  assign count_inc  = payload_count + 16'd1;
  assign crc_got    = {rx_byte, crc_low_byte};

  always_comb begin
    phase_next         = phase;
    running_crc_next   = running_crc;
    frame_type_next    = frame_type;
    frame_length_next  = frame_length;
    payload_count_next = payload_count;
    crc_low_byte_next  = crc_low_byte;
    push               = 1'b0;
    push_data.kind         = KIND_PAYLOAD;
    push_data.payload_byte = 8'h00;
    push_data.packet_type  = frame_type;
    push_data.packet_len   = frame_length;
    push_data.byte_index   = 16'h0000;
    push_data.is_last      = 1'b1;

    if (accept) begin
      if (func == FUNC_TIMEOUT) begin
        // abandon whatever was in progress; only a started frame reports it
        push = (phase != PH_HUNT1) && (phase != PH_HUNT2);
        push_data.kind     = KIND_TIMEOUT;
        phase_next         = PH_HUNT1;
        running_crc_next   = 16'h0000;
        frame_type_next    = 8'h00;
        frame_length_next  = 16'h0000;
        payload_count_next = 16'h0000;
        crc_low_byte_next  = 8'h00;
      end else begin
        case (phase)
          PH_HUNT1: begin
            if (rx_byte == SYNC_FIRST) phase_next = PH_HUNT2;
          end
          PH_HUNT2: begin
            if (rx_byte == SYNC_SECOND) begin
              phase_next         = PH_TYPE;
              running_crc_next   = 16'h0000;
              frame_type_next    = 8'h00;
              frame_length_next  = 16'h0000;
              payload_count_next = 16'h0000;
              crc_low_byte_next  = 8'h00;
            end else if (rx_byte != SYNC_FIRST) begin
              phase_next = PH_HUNT1;
            end
          end
          PH_TYPE: begin
            frame_type_next  = rx_byte;
            running_crc_next = crc_upd;
            phase_next       = PH_LEN_L;
          end
          PH_LEN_L: begin
            frame_length_next = {8'h00, rx_byte};
            running_crc_next  = crc_upd;
            phase_next        = PH_LEN_H;
          end
          PH_LEN_H: begin
            frame_length_next  = len_full;
            running_crc_next   = crc_upd;
            payload_count_next = 16'h0000;
            if (len_full > max_len) begin
              // oversize: report with the full header, then drop the frame
              push                 = 1'b1;
              push_data.kind       = KIND_LEN_ERR;
              push_data.packet_len = len_full;
              phase_next           = PH_HUNT1;
              running_crc_next     = 16'h0000;
              frame_type_next      = 8'h00;
              frame_length_next    = 16'h0000;
              crc_low_byte_next    = 8'h00;
            end else if (len_full == 16'h0000) begin
              phase_next = PH_CRC_L;
            end else begin
              phase_next = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            push                   = 1'b1;
            push_data.kind         = KIND_PAYLOAD;
            push_data.payload_byte = rx_byte;
            push_data.byte_index   = payload_count;
            push_data.is_last      = 1'b0;
            running_crc_next       = crc_upd;
            payload_count_next     = count_inc;
            if (count_inc >= frame_length) phase_next = PH_CRC_L;
          end
          PH_CRC_L: begin
            crc_low_byte_next = rx_byte;
            phase_next        = PH_CRC_H;
          end
          PH_CRC_H: begin
            push               = 1'b1;
            push_data.kind     = (crc_got == running_crc) ? KIND_GOOD : KIND_CRC_ERR;
            phase_next         = PH_HUNT1;
            running_crc_next   = 16'h0000;
            frame_type_next    = 8'h00;
            frame_length_next  = 16'h0000;
            payload_count_next = 16'h0000;
            crc_low_byte_next  = 8'h00;
          end
          default: begin
            phase_next = PH_HUNT1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT1;
      running_crc   <= 16'h0000;
      frame_type    <= 8'h00;
      frame_length  <= 16'h0000;
      payload_count <= 16'h0000;
      crc_low_byte  <= 8'h00;
      max_len       <= MAX_LEN_RESET;
    end else begin
      phase         <= phase_next;
      running_crc   <= running_crc_next;
      frame_type    <= frame_type_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      crc_low_byte  <= crc_low_byte_next;
      if (cfg_wr) max_len <= cfg_data;
    end
  end

  `DFR_ASSERT(a_push_needs_accept, push |-> accept, "result pushed without an accepted item")
  `DFR_ASSERT(a_payload_not_last, (push && push_data.kind == KIND_PAYLOAD) |-> !push_data.is_last, "payload result marked last")
  `DFR_NEVER(a_payload_past_len, phase == PH_PAYLOAD && payload_count >= frame_length, "payload count ran past frame length")

endmodule

// ===== src/dfr_fifo.sv =====
// Short result queue decoupling the parser from the output stage
`include "assert_macros.svh"

module dfr_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  dfr_pkg::result_t  push_data,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output dfr_pkg::result_t  q_data
);
  import dfr_pkg::*;

  result_t            entries [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]  count, count_next;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_data  = entries[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) count_next = count + QCNT_W'(1);
    else if (pop && !push) count_next = count - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
    end
  end

  `DFR_NEVER(a_no_overflow, push && full, "push into full result queue")
  `DFR_NEVER(a_no_underflow, pop && !q_valid, "pop from empty result queue")

endmodule

// ===== src/dfr_back.sv =====
// Output register stage: holds one result until it is transferred
`include "assert_macros.svh"

module dfr_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  dfr_pkg::result_t  q_data,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_stall,
  output dfr_pkg::result_t  res
);
  import dfr_pkg::*;

  // refill whenever the register is empty or its content leaves this cycle
  assign pop = q_valid && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (pop) res <= q_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (pop) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  `DFR_ASSERT(a_pop_fills, pop |=> res_valid, "popped result not presented")

endmodule

// ===== tb/tb_crc16_packet_deframer_core.sv =====
// Self-checking testbench for the CRC-16 packet deframer core
`timescale 1ns / 100ps

module tb_crc16_packet_deframer_core;
  import dfr_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam int LONG_HOLD   = 200;
  localparam int DRAIN_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        func = FUNC_BYTE;
  logic [7:0]  rx_byte = 8'h00;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  payload_byte;
  logic [7:0]  packet_type;
  logic [15:0] packet_len;
  logic [15:0] byte_index;
  logic        is_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = 16'h0000;

  // deframer state as predicted
  phase_t      cur_phase = PH_HUNT1;
  logic [15:0] cur_crc = 16'h0000;
  logic [7:0]  cur_type = 8'h00;
  logic [15:0] cur_len = 16'h0000;
  logic [15:0] cur_count = 16'h0000;
  logic [7:0]  crc_lo_seen = 8'h00;
  logic [15:0] len_limit = MAX_LEN_RESET;

  result_t     frame_outputs_due[$];
  int          fail_count = 0;
  int          items_done = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;
  bit          hold_request = 1'b0;

  crc16_packet_deframer_core dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .func         (func),
    .rx_byte      (rx_byte),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .kind         (kind),
    .payload_byte (payload_byte),
    .packet_type  (packet_type),
    .packet_len   (packet_len),
    .byte_index   (byte_index),
    .is_last      (is_last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // CRC-16, poly 0x1021, one input bit at a time
  function automatic logic [15:0] crc_bitwise(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

  function automatic void frame_restart();
    cur_phase   = PH_HUNT1;
    cur_crc     = 16'h0000;
    cur_type    = 8'h00;
    cur_len     = 16'h0000;
    cur_count   = 16'h0000;
    crc_lo_seen = 8'h00;
  endfunction

  function automatic void queue_output(input logic [2:0] k, input logic [7:0] data,
                                       input logic [15:0] idx, input logic last);
    result_t r;
    r.kind         = k;
    r.payload_byte = data;
    r.packet_type  = cur_type;
    r.packet_len   = cur_len;
    r.byte_index   = idx;
    r.is_last      = last;
    frame_outputs_due.push_back(r);
  endfunction

  function automatic void deframe_step(input logic f, input logic [7:0] b);
    logic [15:0] got;
    if (f == FUNC_TIMEOUT) begin
      if (cur_phase != PH_HUNT1 && cur_phase != PH_HUNT2) begin
        queue_output(KIND_TIMEOUT, 8'h00, 16'h0000, 1'b1);
      end
      frame_restart();
      return;
    end
    case (cur_phase)
      PH_HUNT1: begin
        if (b == SYNC_FIRST) cur_phase = PH_HUNT2;
      end
      PH_HUNT2: begin
        if (b == SYNC_SECOND) begin
          frame_restart();
          cur_phase = PH_TYPE;
        end else if (b != SYNC_FIRST) begin
          cur_phase = PH_HUNT1;
        end
      end
      PH_TYPE: begin
        cur_type  = b;
        cur_crc   = crc_bitwise(16'h0000, b);
        cur_phase = PH_LEN_L;
      end
      PH_LEN_L: begin
        cur_len   = {8'h00, b};
        cur_crc   = crc_bitwise(cur_crc, b);
        cur_phase = PH_LEN_H;
      end
      PH_LEN_H: begin
        cur_len[15:8] = b;
        cur_crc       = crc_bitwise(cur_crc, b);
        cur_count     = 16'h0000;
        if (cur_len > len_limit) begin
          queue_output(KIND_LEN_ERR, 8'h00, 16'h0000, 1'b1);
          frame_restart();
        end else begin
          cur_phase = (cur_len == 16'h0000) ? PH_CRC_L : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        queue_output(KIND_PAYLOAD, b, cur_count, 1'b0);
        cur_crc   = crc_bitwise(cur_crc, b);
        cur_count = cur_count + 16'd1;
        if (cur_count >= cur_len) cur_phase = PH_CRC_L;
      end
      PH_CRC_L: begin
        crc_lo_seen = b;
        cur_phase   = PH_CRC_H;
      end
      default: begin
        got = {b, crc_lo_seen};
        queue_output((got == cur_crc) ? KIND_GOOD : KIND_CRC_ERR, 8'h00, 16'h0000, 1'b1);
        frame_restart();
      end
    endcase
  endfunction

  // one item transfer; valid stays high on return so back-to-back items need no gap
  task automatic send_item(input logic f, input logic [7:0] b);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap != 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid = 1'b1;
    func       = f;
    rx_byte    = b;
    do @(posedge clk); while (item_stall);
    deframe_step(f, b);
    items_done++;
  endtask

  // whole frame; cut_at replaces the byte at that position by a timeout tick and stops
  task automatic send_frame(input logic [7:0] ftype, input logic [15:0] len,
                            input bit bad_crc, input int cut_at);
    logic [7:0]  bytes[$];
    logic [7:0]  b;
    logic [15:0] crc;
    bytes = {SYNC_FIRST, SYNC_SECOND, ftype, len[7:0], len[15:8]};
    crc = crc_bitwise(crc_bitwise(crc_bitwise(16'h0000, ftype), len[7:0]), len[15:8]);
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      bytes.push_back(b);
      crc = crc_bitwise(crc, b);
    end
    if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
    bytes.push_back(crc[7:0]);
    bytes.push_back(crc[15:8]);
    for (int i = 0; i < bytes.size(); i++) begin
      if (i == cut_at) begin
        send_item(FUNC_TIMEOUT, 8'($urandom));
        return;
      end
      send_item(FUNC_BYTE, bytes[i]);
    end
  endtask

  // park the input and let every outstanding result drain
  task automatic wait_idle();
    int n;
    n = 0;
    @(negedge clk);
    item_valid = 1'b0;
    while (frame_outputs_due.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk);
      n++;
    end
    if (frame_outputs_due.size() != 0) begin
      $error("%0d results never arrived", frame_outputs_due.size());
      fail_count++;
      frame_outputs_due.delete();
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    wait_idle();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    len_limit = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic test_sync_hunt();
    send_item(FUNC_BYTE, 8'hFF);
    send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, SYNC_FIRST);
    send_item(FUNC_BYTE, 8'h00);
    // doubled first sync byte, then an all-zero frame of zero length
    send_item(FUNC_BYTE, SYNC_FIRST);
    send_item(FUNC_BYTE, SYNC_FIRST);
    send_item(FUNC_BYTE, SYNC_SECOND);
    repeat (5) send_item(FUNC_BYTE, 8'h00);
    send_item(FUNC_BYTE, SYNC_FIRST);
    send_item(FUNC_TIMEOUT, 8'hFF);
    send_item(FUNC_TIMEOUT, 8'h00);
  endtask

  task automatic test_frame_outcomes();
    send_frame(8'h80, 16'd2, 1'b1, -1);
    send_frame(8'h7F, 16'd1, 1'b0, -1);
    send_frame(8'h07, 16'd4, 1'b0, 4);
  endtask

  task automatic test_length_limit();
    // reset limit: 1017 passes, 1018 is flagged
    send_frame(8'h11, 16'd1017, 1'b0, 7);
    send_frame(8'h12, 16'd1018, 1'b0, 5);
    write_max_len(16'd0);
    send_frame(8'h21, 16'd0, 1'b0, -1);
    send_frame(8'h22, 16'd1, 1'b0, -1);
    write_max_len(16'hFFFF);
    send_frame(8'hFF, 16'hFFFF, 1'b0, 8);
    write_max_len(16'd3);
    send_frame(8'h33, 16'd3, 1'b0, -1);
    send_frame(8'h34, 16'd4, 1'b0, -1);
    write_max_len(MAX_LEN_RESET);
  endtask

  task automatic test_output_backpressure();
    tx_gaps      = 1'b0;
    hold_request = 1'b1;
    send_frame(8'h3C, 16'd60, 1'b0, -1);
    wait_idle();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    int          frames;
    int          sel;
    int          cut;
    int          over;
    logic [15:0] len;
    frames = 0;
    while (items_done < ITEM_TARGET) begin
      if (frames % 40 == 0) begin
        sel = $urandom_range(0, 9);
        if (sel == 0) write_max_len(16'd0);
        else if (sel < 3) write_max_len(16'hFFFF);
        else if (sel < 5) write_max_len(MAX_LEN_RESET);
        else write_max_len(16'($urandom_range(8, 300)));
        tx_gaps = ($urandom_range(0, 3) != 0);
        rx_gaps = ($urandom_range(0, 3) != 0);
      end
      frames++;
      sel = $urandom_range(0, 99);
      if (sel < 70) begin
        sel = $urandom_range(0, 99);
        if (sel < 75) len = 16'($urandom_range(0, 12));
        else if (sel < 95) len = 16'($urandom_range(13, 64));
        else len = 16'($urandom_range(65, 300));
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 6 + int'(len)) : -1;
        send_frame(8'($urandom), len, ($urandom_range(0, 3) == 0), cut);
      end else if (sel < 80) begin
        over = int'(len_limit) + 1 + $urandom_range(0, 15);
        // oversize header; the tail that follows is line noise
        if (over <= 16'hFFFF) begin
          send_frame(8'($urandom), 16'(over), 1'b0, 5 + $urandom_range(0, 8));
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          sel = $urandom_range(0, 99);
          if (sel < 15) send_item(FUNC_TIMEOUT, 8'($urandom));
          else if (sel < 35) send_item(FUNC_BYTE, SYNC_FIRST);
          else if (sel < 55) send_item(FUNC_BYTE, SYNC_SECOND);
          else send_item(FUNC_BYTE, 8'($urandom));
        end
      end
    end
  endtask

  // result side: random stall before each transfer, one long hold on request
  initial begin
    int unsigned n;
    while (rst) @(negedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        res_stall = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end
      n = rx_gaps ? $urandom_range(0, 9) : 0;
      if (n != 0) begin
        res_stall = 1'b1;
        repeat (n) @(negedge clk);
      end
      res_stall = 1'b0;
      do @(posedge clk); while (!res_valid);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (!rst && res_valid && !res_stall) begin
      if (frame_outputs_due.size() == 0) begin
        $error("unexpected result: kind %0d", kind);
        fail_count++;
      end else begin
        e = frame_outputs_due.pop_front();
        if (kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, kind);
          fail_count++;
        end
        if (payload_byte !== e.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", e.payload_byte, payload_byte);
          fail_count++;
        end
        if (packet_type !== e.packet_type) begin
          $error("packet_type: expected %0h, got %0h", e.packet_type, packet_type);
          fail_count++;
        end
        if (packet_len !== e.packet_len) begin
          $error("packet_len: expected %0d, got %0d", e.packet_len, packet_len);
          fail_count++;
        end
        if (byte_index !== e.byte_index) begin
          $error("byte_index: expected %0d, got %0d", e.byte_index, byte_index);
          fail_count++;
        end
        if (is_last !== e.is_last) begin
          $error("is_last: expected %0b, got %0b", e.is_last, is_last);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_sync_hunt();
    test_frame_outcomes();
    test_length_limit();
    test_output_backpressure();
    test_random_traffic();
    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/dfr_pkg.sv
src/dfr_front.sv
src/dfr_fifo.sv
src/dfr_back.sv
src/crc16_packet_deframer_core.sv
tb/tb_crc16_packet_deframer_core.sv
